[rtl/rdz_pkg.sv]
// Shared constants and types for the radial dead-zone remap pipeline.
// Used by rdz_sqrt, rdz_div and radial_dead_zone_remap.
`timescale 1ns / 1ps
`default_nettype none
package rdz_pkg;
  localparam int SampleBits = 16;
  localparam int FracBits   = SampleBits - 1;
  localparam int SqBits     = 2 * SampleBits;
  localparam int FixedBits  = SampleBits + 1;
  localparam int RootSteps  = SqBits / 2;
  localparam int QuotSteps  = SampleBits;

  // stream widths: input is two samples, output is padded up to whole bytes
  localparam int InBits       = 2 * SampleBits;
  localparam int OutFieldBits = 2 * FixedBits + 3 * SampleBits;
  localparam int OutBits      = (OutFieldBits + 7) / 8 * 8;
  localparam int MagLsb       = 2 * FixedBits;

  // register indexes on the config port
  localparam logic CfgInner = 1'b0;
  localparam logic CfgOuter = 1'b1;

  localparam logic [SampleBits-1:0] OneQ = SampleBits'(1) << FracBits;

  // payload that travels alongside the arithmetic units
  typedef struct packed {
    logic signed [SampleBits-1:0] raw_x;
    logic signed [SampleBits-1:0] raw_y;
    logic [SampleBits-1:0]        ax;
    logic [SampleBits-1:0]        ay;
    logic                         nx;
    logic                         ny;
    logic [SampleBits-1:0]        len;
    logic                         zero;
    logic [SampleBits-1:0]        mag;
  } rdz_item_t;
endpackage
`default_nettype wire

[rtl/radial_dead_zone_remap.sv]
// Radial dead-zone remap for a two-axis stick sample: length, clamp, rescale.
// Depends on rdz_pkg, rdz_sqrt and rdz_div.
`timescale 1ns / 1ps
`default_nettype none
// One sample may enter every cycle while the output side does not stall. Each
// result passes through the 16-stage square root and the two 16-stage divider
// chains (length remap, then axis rescale), plus the abs, square, sum, clamp,
// multiply and output registers. The whole pipeline holds when the output
// register is full and not taken, so s_tready follows m_tready
// combinationally.
module radial_dead_zone_remap (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [rdz_pkg::SampleBits-1:0]    cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rdz_pkg::InBits-1:0]        s_tdata,  // raw_x[15:0], raw_y[31:16]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // fixed_x[16:0], fixed_y[33:17], magnitude[49:34], echo_x[65:50],
  // echo_y[81:66], zero pad [87:82]
  output logic [rdz_pkg::OutBits-1:0]            m_tdata
);
  import rdz_pkg::*;

  logic en;
  logic [SampleBits-1:0] inner_radius, outer_radius;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= '0;
      outer_radius <= OneQ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgInner: inner_radius <= cfg_data;
        CfgOuter: outer_radius <= cfg_data;
        default:  ;
      endcase
    end
  end

  // stage A: absolute values
  logic      va;
  rdz_item_t ia, ia_next;
  logic signed [SampleBits-1:0] in_x, in_y;
  assign in_x = s_tdata[SampleBits-1:0];
  assign in_y = s_tdata[2*SampleBits-1:SampleBits];

  always_comb begin
    ia_next       = '0;
    ia_next.raw_x = in_x;
    ia_next.raw_y = in_y;
    ia_next.nx    = in_x[SampleBits-1];
    ia_next.ny    = in_y[SampleBits-1];
    ia_next.ax    = in_x[SampleBits-1] ? SampleBits'(-in_x) : SampleBits'(in_x);
    ia_next.ay    = in_y[SampleBits-1] ? SampleBits'(-in_y) : SampleBits'(in_y);
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia <= ia_next;
    end
  end

  // stage B: squares
  logic              vb;
  rdz_item_t         ib;
  logic [SqBits-1:0] sqx, sqy;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ib  <= ia;
      sqx <= ia.ax * ia.ax;
      sqy <= ia.ay * ia.ay;
    end
  end

  // stage C: squared length, fits since each square is at most 2^30
  logic              vc;
  rdz_item_t         ic;
  logic [SqBits-1:0] sum;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ic  <= ib;
      sum <= sqx + sqy;
    end
  end

  // radial length
  logic                  vr;
  logic [SampleBits-1:0] root;
  rdz_item_t             ir;
  rdz_sqrt u_sqrt (
    .clk, .rst, .en,
    .valid_in (vc), .radicand (sum), .item_in (ic),
    .valid_out(vr), .root_out (root), .item_out(ir)
  );

  // stage D: clamp into the band, build the remap division
  logic                  vd;
  rdz_item_t             id, id_next;
  logic [SqBits-1:0]     dnum;
  logic [SampleBits-1:0] dden, clamped, lo_clamp;
  assign lo_clamp = (root < inner_radius) ? inner_radius : root;
  assign clamped  = (lo_clamp > outer_radius) ? outer_radius : lo_clamp;

  always_comb begin
    id_next      = ir;
    id_next.len  = root;
    id_next.zero = (root == '0) || !(outer_radius > inner_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vr;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      id      <= id_next;
      dnum    <= {1'b0, SampleBits'(clamped - inner_radius), FracBits'(0)};
      dden    <= outer_radius - inner_radius;
    end
  end

  // corrected magnitude
  logic                  vm;
  logic [SampleBits-1:0] mq;
  rdz_item_t             im;
  rdz_div u_div_mag (
    .clk, .rst, .en,
    .valid_in (vd), .num (dnum), .den (dden), .item_in (id),
    .valid_out(vm), .quot (mq), .item_out (im)
  );

  // stage E: scale each axis by the new length
  logic              ve;
  rdz_item_t         ie, ie_next;
  logic [SqBits-1:0] px, py;

  always_comb begin
    ie_next     = im;
    ie_next.mag = mq;
  end

  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else if (en) ve <= vm;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ie     <= ie_next;
      px     <= im.ax * mq;
      py     <= im.ay * mq;
    end
  end

  // divide by the raw length
  logic                  vx;
  logic [SampleBits-1:0] qx, qy;
  rdz_item_t             ix;
  rdz_div u_div_x (
    .clk, .rst, .en,
    .valid_in (ve), .num (px), .den (ie.len), .item_in (ie),
    .valid_out(vx), .quot (qx), .item_out (ix)
  );
  rdz_div u_div_y (
    .clk, .rst, .en,
    .valid_in (ve), .num (py), .den (ie.len), .item_in (ie),
    .valid_out(), .quot (qy), .item_out ()
  );

  // output register: sign, zero cases, packing
  logic [FixedBits-1:0]  fx, fy, ox, oy;
  logic [SampleBits-1:0] om;
  assign fx = ix.nx ? FixedBits'(-{1'b0, qx}) : {1'b0, qx};
  assign fy = ix.ny ? FixedBits'(-{1'b0, qy}) : {1'b0, qy};
  assign ox = ix.zero ? '0 : fx;
  assign oy = ix.zero ? '0 : fy;
  assign om = ix.zero ? '0 : ix.mag;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vx;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OutBits'({ix.raw_y, ix.raw_x, om, oy, ox});
    end
  end

  // never above full deflection
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[MagLsb +: SampleBits] <= OneQ))
    else $error("magnitude above one");

  // zero magnitude gives zero position
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[MagLsb +: SampleBits] == '0) |-> (m_tdata[MagLsb-1:0] == '0))
    else $error("position nonzero at zero magnitude");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
endmodule
`default_nettype wire

[rtl/rdz_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on rdz_pkg; carries an rdz_item_t payload with each beat.
`timescale 1ns / 1ps
`default_nettype none
module rdz_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [rdz_pkg::SqBits-1:0]    radicand,
  input  wire rdz_pkg::rdz_item_t            item_in,
  output logic                               valid_out,
  output logic [rdz_pkg::SampleBits-1:0]     root_out,
  output rdz_pkg::rdz_item_t                 item_out
);
  import rdz_pkg::*;

  localparam int RemBits = SampleBits + 2;

  logic                  vld  [0:RootSteps];
  logic [SqBits-1:0]     rad  [0:RootSteps];
  logic [RemBits-1:0]    rem  [0:RootSteps];
  logic [SampleBits-1:0] root [0:RootSteps];
  rdz_item_t             item [0:RootSteps];

  assign vld[0]  = valid_in;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign item[0] = item_in;

  // stage k takes the next two radicand bits and decides one root bit
  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    logic [RemBits+1:0] shifted;
    logic [RemBits+1:0] trial;
    logic               take;
    assign shifted = {rem[k], rad[k][SqBits-1-2*k -: 2]};
    assign trial   = {(RemBits+2-SampleBits-2)'(0), root[k], 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= rad[k];
        item[k+1] <= item[k];
        rem[k+1]  <= take ? RemBits'(shifted - trial) : RemBits'(shifted);
        root[k+1] <= {root[k][SampleBits-2:0], take};
      end
    end
  end

  assign valid_out = vld[RootSteps];
  assign root_out  = root[RootSteps];
  assign item_out  = item[RootSteps];
endmodule
`default_nettype wire

[rtl/rdz_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rdz_pkg; quotient must fit SampleBits; carries an rdz_item_t.
`timescale 1ns / 1ps
`default_nettype none
module rdz_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [rdz_pkg::SqBits-1:0]    num,
  input  wire logic [rdz_pkg::SampleBits-1:0] den,
  input  wire rdz_pkg::rdz_item_t            item_in,
  output logic                               valid_out,
  output logic [rdz_pkg::SampleBits-1:0]     quot,
  output rdz_pkg::rdz_item_t                 item_out
);
  import rdz_pkg::*;

  logic                  vld [0:QuotSteps];
  logic [SampleBits-1:0] lo  [0:QuotSteps];
  logic [SampleBits-1:0] rem [0:QuotSteps];
  logic [SampleBits-1:0] dv  [0:QuotSteps];
  logic [SampleBits-1:0] q   [0:QuotSteps];
  rdz_item_t             item [0:QuotSteps];

  assign vld[0]  = valid_in;
  assign lo[0]   = num[SampleBits-1:0];
  assign rem[0]  = num[SqBits-1:SampleBits];
  assign dv[0]   = den;
  assign q[0]    = '0;
  assign item[0] = item_in;

  // shift in one numerator bit, subtract when it fits
  for (genvar k = 0; k < QuotSteps; k++) begin : g_step
    logic [SampleBits:0] part;
    logic                take;
    assign part = {rem[k], lo[k][SampleBits-1-k]};
    assign take = part >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo[k+1]   <= lo[k];
        dv[k+1]   <= dv[k];
        item[k+1] <= item[k];
        rem[k+1]  <= take ? SampleBits'(part - {1'b0, dv[k]}) : SampleBits'(part);
        q[k+1]    <= {q[k][SampleBits-2:0], take};
      end
    end
  end

  assign valid_out = vld[QuotSteps];
  assign quot      = q[QuotSteps];
  assign item_out  = item[QuotSteps];
endmodule
`default_nettype wire
